// ===== hdl/pcmsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM sample format converter package
// Payload structures, sample kind codes and configuration register indexes.
// ----------------------------------------------------------------------------
package pcmsfc_pkg;

  // Sample kind codes carried by in_kind.
  localparam logic [2:0] KIND_I8  = 3'd0;
  localparam logic [2:0] KIND_I16 = 3'd1;
  localparam logic [2:0] KIND_I32 = 3'd2;
  localparam logic [2:0] KIND_F32 = 3'd3;
  localparam logic [2:0] KIND_F64 = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_OUT_SAMPLE_BITS = 2'd0;
  localparam logic [1:0] REG_OUT_IS_FLOAT    = 2'd1;

  // One input sample.
  typedef struct packed {
    logic [63:0] sample_raw;
    logic [2:0]  in_kind;
    logic [5:0]  sig_bits;
    logic        is_last;
  } pcmsfc_in_t;

  // One converted sample.
  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        error;
    logic        last_out;
  } pcmsfc_out_t;

endpackage

// ===== hdl/pcm_sample_format_converter_unit.sv =====
// ----------------------------------------------------------------------------
// PCM sample format converter
// Converts one integer or IEEE float audio sample into the configured output
// format (integer PCM 16/24/32 or float32/float64), little-endian bytes.
// ----------------------------------------------------------------------------
// The sample passes through the input register, is converted combinationally
// and is registered in the result register, which drives out_valid and out_item.
// Throughput: one sample per cycle; busy stays low, a new sample may follow
// every cycle through the input register and the result register.
// Reset: synchronous active-low reset clears the pipeline valid flags and
// sets the output format to 16-bit integer PCM.
module pcm_sample_format_converter_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  pcmsfc_pkg::pcmsfc_in_t    in_item,
  output logic                      out_valid,
  output pcmsfc_pkg::pcmsfc_out_t   out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [7:0]                cfg_data
);

  logic [6:0]              osb_r;
  logic                    ofl_r;
  logic                    in_vld_r;
  pcmsfc_pkg::pcmsfc_in_t  in_r;
  logic                    out_vld_r;
  pcmsfc_pkg::pcmsfc_out_t out_r;
  pcmsfc_pkg::pcmsfc_out_t res_nxt;

  // Decode of the registered sample.
  logic [63:0]        raw;
  logic [2:0]         kind;
  logic [5:0]         sig6;
  logic [6:0]         bps;
  logic               wide;
  logic               in_float;
  logic signed [31:0] ival;
  logic [7:0]         e8;
  logic [22:0]        m23;
  logic [10:0]        e11;
  logic [51:0]        m52;
  logic               nan32;
  logic               nan64;

  // Integer to integer.
  logic signed [7:0]  sh;
  logic [5:0]         rsh;
  logic [31:0]        ii_u;

  // Float to integer.
  logic               fi_sign;
  logic signed [12:0] fi_e;
  logic [52:0]        fi_m;
  logic               fi_zero;
  logic signed [12:0] fi_ep;
  logic               fi_sat;
  logic [5:0]         fi_sh;
  logic [52:0]        fi_h;
  logic [33:0]        fi_r;
  logic [32:0]        fi_mag;
  logic [32:0]        scl;
  logic [32:0]        fi_pos;
  logic [32:0]        fi_neg;
  logic [32:0]        fi_s;
  logic [31:0]        fi_u;

  // Normalizer for integers and float32 subnormals.
  logic [31:0]        nz_x;
  logic signed [12:0] nz_k;
  logic [4:0]         nz_p;
  logic signed [12:0] nz_e;
  logic [52:0]        nz_m;

  // Float output source and packing.
  logic               fo_sign;
  logic signed [12:0] fo_e;
  logic [52:0]        fo_m;
  logic               fo_zero;
  logic               fo_inf;
  logic signed [12:0] e64;
  logic [63:0]        pk64;
  logic signed [12:0] be;
  logic [5:0]         s_amt;
  logic [107:0]       t_sh;
  logic [52:0]        q;
  logic               rnd;
  logic [7:0]         base;
  logic [30:0]        bits31;
  logic [31:0]        pk32;
  logic [63:0]        fo_bytes;

  logic [31:0]        int_u;
  logic [63:0]        int_bytes;
  logic               err;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osb_r <= 7'd16;
      ofl_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcmsfc_pkg::REG_OUT_SAMPLE_BITS: osb_r <= cfg_data[6:0];
        pcmsfc_pkg::REG_OUT_IS_FLOAT:    ofl_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_item;
    end
  end

  // Field decode.
  always_comb begin
    raw      = in_r.sample_raw;
    kind     = in_r.in_kind;
    sig6     = (in_r.sig_bits == 6'd0) ? 6'd1 : in_r.sig_bits;
    bps      = osb_r;
    wide     = (bps == 7'd64);
    in_float = (kind == pcmsfc_pkg::KIND_F32) || (kind == pcmsfc_pkg::KIND_F64);
    case (kind)
      pcmsfc_pkg::KIND_I8:  ival = {{24{raw[7]}}, raw[7:0]};
      pcmsfc_pkg::KIND_I16: ival = {{16{raw[15]}}, raw[15:0]};
      default:              ival = raw[31:0];
    endcase
    e8    = raw[30:23];
    m23   = raw[22:0];
    e11   = raw[62:52];
    m52   = raw[51:0];
    nan32 = (e8 == 8'hFF) && (m23 != 23'd0);
    nan64 = (e11 == 11'h7FF) && (m52 != 52'd0);
  end

  // Integer to integer: shift to the output width, arithmetic on right shifts.
  always_comb begin
    sh   = $signed({1'b0, bps}) - $signed({2'b00, sig6});
    rsh  = 6'(-sh);
    ii_u = 32'd0;
    if (sh >= 8'sd0) begin
      ii_u = (sh >= 8'sd32) ? 32'd0 : 32'(ival << sh[4:0]);
    end else begin
      ii_u = 32'(ival >>> rsh);
    end
  end

  // Float to integer: scale, round half away from zero, clamp.
  always_comb begin
    if (kind == pcmsfc_pkg::KIND_F32) begin
      fi_sign = raw[31];
      fi_e    = $signed({5'd0, e8}) - 13'sd127;
      fi_m    = {1'b1, m23, 29'd0};
      fi_zero = (e8 == 8'd0) || nan32;
    end else begin
      fi_sign = raw[63];
      fi_e    = $signed({2'd0, e11}) - 13'sd1023;
      fi_m    = {1'b1, m52};
      fi_zero = (e11 == 11'd0) || nan64;
    end
    fi_ep  = fi_e + $signed({6'd0, bps}) - 13'sd1;
    fi_sat = !fi_zero && (fi_ep >= 13'sd32);
    fi_sh  = 6'(13'sd51 - fi_ep);
    fi_h   = fi_m >> fi_sh;
    fi_r   = {1'b0, fi_h[32:0]} + 34'd1;
    if (fi_zero || fi_ep <= -13'sd3 || fi_sat) begin
      fi_mag = 33'd0;
    end else if (fi_ep == -13'sd2) begin
      // Just below one half rounds up to one when the add of one half rounds.
      fi_mag = {32'd0, &fi_m};
    end else begin
      fi_mag = fi_r[33:1];
    end
    scl    = 33'd1 << (bps - 7'd1);
    fi_pos = (fi_sat || fi_mag >= scl) ? scl - 33'd1 : fi_mag;
    fi_neg = (fi_sat || fi_mag > scl) ? scl : fi_mag;
    fi_s   = fi_sign ? (33'd0 - fi_neg) : fi_pos;
    fi_u   = fi_s[31:0];
  end

  // Leading-one normalizer.
  always_comb begin
    if (kind == pcmsfc_pkg::KIND_F32) begin
      nz_x = {9'd0, m23};
      nz_k = -13'sd149;
    end else begin
      nz_x = ival[31] ? 32'(-ival) : 32'(ival);
      nz_k = 13'sd1 - $signed({7'd0, sig6});
    end
    nz_p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (nz_x[i]) begin
        nz_p = 5'(i);
      end
    end
    nz_e = $signed({8'd0, nz_p}) + nz_k;
    nz_m = {21'd0, nz_x} << (6'd52 - {1'b0, nz_p});
  end

  // Float output: select the source value.
  always_comb begin
    if (kind == pcmsfc_pkg::KIND_F64) begin
      fo_sign = raw[63];
      fo_e    = $signed({2'd0, e11}) - 13'sd1023;
      fo_m    = {(e11 != 11'd0), m52};
      fo_zero = 1'b0;
      fo_inf  = (e11 == 11'h7FF);
    end else if (kind == pcmsfc_pkg::KIND_F32 && e8 != 8'd0) begin
      fo_sign = raw[31];
      fo_e    = $signed({5'd0, e8}) - 13'sd127;
      fo_m    = {1'b1, m23, 29'd0};
      fo_zero = 1'b0;
      fo_inf  = (e8 == 8'hFF);
    end else begin
      fo_sign = (kind == pcmsfc_pkg::KIND_F32) ? raw[31] : ival[31];
      fo_e    = nz_e;
      fo_m    = nz_m;
      fo_zero = (nz_x == 32'd0);
      fo_inf  = 1'b0;
    end
  end

  // Pack as float64 (always exact here).
  always_comb begin
    e64 = fo_e + 13'sd1023;
    if (fo_zero) begin
      pk64 = {fo_sign, 63'd0};
    end else if (fo_inf) begin
      pk64 = {fo_sign, 11'h7FF, 52'd0};
    end else begin
      pk64 = {fo_sign, e64[10:0], fo_m[51:0]};
    end
  end

  // Pack as float32 with round to nearest even, subnormals and overflow.
  always_comb begin
    be = fo_e + 13'sd127;
    if (be >= 13'sd1) begin
      s_amt = 6'd29;
    end else if (be < -13'sd25) begin
      s_amt = 6'd55;
    end else begin
      s_amt = 6'(13'sd30 - be);
    end
    t_sh   = {fo_m, 55'd0} >> s_amt;
    q      = t_sh[107:55];
    rnd    = t_sh[54] && ((|t_sh[53:0]) || q[0]);
    base   = (be >= 13'sd1) ? 8'(be - 13'sd1) : 8'd0;
    bits31 = {base, 23'd0} + q[30:0] + {30'd0, rnd};
    if (fo_zero) begin
      pk32 = {fo_sign, 31'd0};
    end else if (fo_inf || be >= 13'sd255) begin
      pk32 = {fo_sign, 8'hFF, 23'd0};
    end else begin
      pk32 = {fo_sign, bits31};
    end
  end

  // Float output selection, including pass-through and NaN cases.
  always_comb begin
    if (kind == pcmsfc_pkg::KIND_F32 && !wide) begin
      fo_bytes = {32'd0, raw[31:0]};
    end else if (kind == pcmsfc_pkg::KIND_F64 && wide) begin
      fo_bytes = raw;
    end else if (kind == pcmsfc_pkg::KIND_F32 && nan32) begin
      fo_bytes = {raw[31], 11'h7FF, 1'b1, m23[21:0], 29'd0};
    end else if (kind == pcmsfc_pkg::KIND_F64 && nan64) begin
      fo_bytes = {32'd0, raw[63], 8'hFF, 1'b1, raw[50:29]};
    end else if (kind == pcmsfc_pkg::KIND_F64) begin
      fo_bytes = {32'd0, pk32};
    end else if (kind == pcmsfc_pkg::KIND_F32 || wide) begin
      fo_bytes = pk64;
    end else begin
      fo_bytes = {32'd0, pk32};
    end
  end

  // Result assembly.
  always_comb begin
    int_u = in_float ? fi_u : ii_u;
    case (bps)
      7'd16:   int_bytes = {48'd0, int_u[15:0]};
      7'd24:   int_bytes = {40'd0, int_u[23:0]};
      default: int_bytes = {32'd0, int_u};
    endcase
    err = (kind > pcmsfc_pkg::KIND_F64) ||
          (!ofl_r && bps != 7'd16 && bps != 7'd24 && bps != 7'd32);
    res_nxt.last_out = in_r.is_last;
    res_nxt.error    = err;
    if (err) begin
      res_nxt.out_bytes  = 64'd0;
      res_nxt.byte_count = 4'd0;
    end else if (ofl_r) begin
      res_nxt.out_bytes  = fo_bytes;
      res_nxt.byte_count = wide ? 4'd8 : 4'd4;
    end else begin
      res_nxt.out_bytes  = int_bytes;
      res_nxt.byte_count = bps[6:3];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_r <= res_nxt;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// PCM sample format converter testbench
// Drives directed and random samples through several output formats and
// compares every converted sample with a built-in model of the conversion.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 6;

  // Expected-result store and conversion model.
  class sample_scoreboard;
    logic [6:0]              out_bits;
    logic                    out_float;
    pcmsfc_pkg::pcmsfc_out_t pending[$];
    int                      failures;
    int                      checked;
    int                      errors_seen;

    function void reset_format();
      out_bits  = 7'd16;
      out_float = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      if (idx == pcmsfc_pkg::REG_OUT_SAMPLE_BITS) out_bits = data[6:0];
      else if (idx == pcmsfc_pkg::REG_OUT_IS_FLOAT) out_float = data[0];
    endfunction

    // Round a double to single precision, nearest even.
    function logic [31:0] narrow_float(logic [63:0] b);
      logic        s;
      int          e, e32, sh;
      logic [63:0] mant, q, rem, half;
      logic [31:0] r;
      s = b[63];
      e = int'(b[62:52]);
      if (e == 2047) return {s, 8'hFF, 23'd0};
      if (e == 0) return {s, 31'd0};
      mant = {11'd0, 1'b1, b[51:0]};
      e32 = e - 1023 + 127;
      if (e32 >= 255) return {s, 8'hFF, 23'd0};
      sh = (e32 >= 1) ? 29 : 30 - e32;
      if (sh > 60) return {s, 31'd0};
      q = mant >> sh;
      rem = mant & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      if (e32 >= 1) r = 32'((e32 - 1) << 23) + q[31:0];
      else r = q[31:0];
      return {s, r[30:0]};
    endfunction

    // Exact widening of a single to a double.
    function logic [63:0] widen_float(logic [31:0] b);
      logic        s;
      int          e, p;
      logic [63:0] t;
      s = b[31];
      e = int'(b[30:23]);
      if (e == 255) return {s, 11'h7FF, 52'd0};
      if (e == 0 && b[22:0] == 0) return {s, 63'd0};
      if (e == 0) begin
        p = 0;
        for (int i = 0; i < 23; i++) if (b[i]) p = i;
        t = 64'(b[22:0]) << (52 - p);
        return {s, 11'(p - 149 + 1023), t[51:0]};
      end
      return {s, 11'(e - 127 + 1023), b[22:0], 29'd0};
    endfunction

    function logic [31:0] int_sample(logic [63:0] raw, logic [2:0] kind);
      if (kind == pcmsfc_pkg::KIND_I8) return {{24{raw[7]}}, raw[7:0]};
      if (kind == pcmsfc_pkg::KIND_I16) return {{16{raw[15]}}, raw[15:0]};
      return raw[31:0];
    endfunction

    function pcmsfc_pkg::pcmsfc_out_t convert(pcmsfc_pkg::pcmsfc_in_t s);
      pcmsfc_pkg::pcmsfc_out_t r;
      int          sig, bps, sh;
      logic        wide, nan;
      logic [31:0] u;
      logic [63:0] dbits;
      real         d, scl;
      r = '0;
      r.last_out = s.is_last;
      sig = (s.sig_bits == 0) ? 1 : int'(s.sig_bits);
      bps = int'(out_bits);
      wide = (bps == 64);
      if (s.in_kind > pcmsfc_pkg::KIND_F64) begin
        r.error = 1'b1;
      end else if (out_float) begin
        if (s.in_kind == pcmsfc_pkg::KIND_F32 && !wide) begin
          r.out_bytes = {32'd0, s.sample_raw[31:0]};
        end else if (s.in_kind == pcmsfc_pkg::KIND_F64 && wide) begin
          r.out_bytes = s.sample_raw;
        end else if (s.in_kind == pcmsfc_pkg::KIND_F32) begin
          if (s.sample_raw[30:23] == 8'hFF && s.sample_raw[22:0] != 0)
            r.out_bytes = {s.sample_raw[31], 12'hFFF, s.sample_raw[21:0], 29'd0};
          else
            r.out_bytes = widen_float(s.sample_raw[31:0]);
        end else if (s.in_kind == pcmsfc_pkg::KIND_F64) begin
          if (s.sample_raw[62:52] == 11'h7FF && s.sample_raw[51:0] != 0)
            r.out_bytes = {32'd0, s.sample_raw[63], 9'h1FF, s.sample_raw[50:29]};
          else
            r.out_bytes = {32'd0, narrow_float(s.sample_raw)};
        end else begin
          d = real'($signed(int_sample(s.sample_raw, s.in_kind)));
          scl = $bitstoreal({1'b0, 11'(1023 + sig - 1), 52'd0});
          dbits = $realtobits(d / scl);
          r.out_bytes = wide ? dbits : {32'd0, narrow_float(dbits)};
        end
        r.byte_count = wide ? 4'd8 : 4'd4;
      end else if (bps != 16 && bps != 24 && bps != 32) begin
        r.error = 1'b1;
      end else begin
        if (s.in_kind == pcmsfc_pkg::KIND_F32 || s.in_kind == pcmsfc_pkg::KIND_F64) begin
          if (s.in_kind == pcmsfc_pkg::KIND_F32) begin
            nan = s.sample_raw[30:23] == 8'hFF && s.sample_raw[22:0] != 0;
            dbits = widen_float(s.sample_raw[31:0]);
          end else begin
            nan = s.sample_raw[62:52] == 11'h7FF && s.sample_raw[51:0] != 0;
            dbits = s.sample_raw;
          end
          u = '0;
          if (!nan) begin
            scl = $bitstoreal({1'b0, 11'(1023 + bps - 1), 52'd0});
            d = $bitstoreal(dbits) * scl;
            if (d >= 0.0) d = d + 0.5;
            else d = d - 0.5;
            if (d >= scl) d = scl - 1.0;
            if (d < -scl) d = -scl;
            u = 32'($rtoi(d));
          end
        end else begin
          // Shift the sign-extended sample to the output width.
          sh = bps - sig;
          u = int_sample(s.sample_raw, s.in_kind);
          if (sh >= 0) u = (sh >= 32) ? 32'd0 : u << sh;
          else if (-sh >= 32) u = {32{u[31]}};
          else u = $unsigned($signed(u) >>> (-sh));
        end
        if (bps == 32) r.out_bytes = {32'd0, u};
        else r.out_bytes = {32'd0, u} & ((64'd1 << bps) - 64'd1);
        r.byte_count = 4'(bps >> 3);
      end
      if (r.error) begin
        r.out_bytes = '0;
        r.byte_count = '0;
      end
      return r;
    endfunction

    function void note_sample(pcmsfc_pkg::pcmsfc_in_t s);
      pending.push_back(convert(s));
    endfunction

    function void check_result(pcmsfc_pkg::pcmsfc_out_t got);
      pcmsfc_pkg::pcmsfc_out_t exp_r;
      if (pending.size() == 0) begin
        $error("Unexpected result transaction: %h", got);
        failures++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (exp_r.error) errors_seen++;
      if (got.out_bytes !== exp_r.out_bytes) begin
        $error("out_bytes: expected %h, got %h", exp_r.out_bytes, got.out_bytes);
        failures++;
      end
      if (got.byte_count !== exp_r.byte_count) begin
        $error("byte_count: expected %0d, got %0d", exp_r.byte_count, got.byte_count);
        failures++;
      end
      if (got.error !== exp_r.error) begin
        $error("error: expected %b, got %b", exp_r.error, got.error);
        failures++;
      end
      if (got.last_out !== exp_r.last_out) begin
        $error("last_out: expected %b, got %b", exp_r.last_out, got.last_out);
        failures++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  pcmsfc_pkg::pcmsfc_in_t  in_item = '0;
  logic                    out_valid;
  pcmsfc_pkg::pcmsfc_out_t out_item;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index = '0;
  logic [7:0]              cfg_data = '0;

  sample_scoreboard sb = new();
  int quiet_cycles = 0;
  int samples_sent = 0;

  always #6 clk = ~clk;

  pcm_sample_format_converter_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Observe every transaction on the three channels and run the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_sample(in_item);
      if (out_valid) sb.check_result(out_item);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results pending", sb.pending.size());
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one sample, wait for its transaction, then idle a random gap.
  task automatic send_sample(pcmsfc_pkg::pcmsfc_in_t s);
    int gap;
    gap = $urandom_range(0, 5);
    start = 1'b1;
    in_item = s;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 1'b0;
    repeat (gap) @(negedge clk);
    samples_sent++;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic pcmsfc_pkg::pcmsfc_in_t make_sample(logic [63:0] raw,
                                                         logic [2:0] kind,
                                                         logic [5:0] sig);
    pcmsfc_pkg::pcmsfc_in_t s;
    s.sample_raw = raw;
    s.in_kind = kind;
    s.sig_bits = sig;
    s.is_last = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Random sample: mostly valid kinds, floats often near full scale.
  function automatic pcmsfc_pkg::pcmsfc_in_t random_sample();
    logic [63:0] raw;
    logic [2:0]  kind;
    logic [5:0]  sig;
    raw = {$urandom(), $urandom()};
    kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                       : 3'($urandom_range(0, 4));
    sig = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                      : 6'($urandom_range(1, 32));
    if (kind == pcmsfc_pkg::KIND_F32 && $urandom_range(0, 2) != 0)
      raw[30:23] = 8'($urandom_range(100, 128));
    if (kind == pcmsfc_pkg::KIND_F64 && $urandom_range(0, 2) != 0)
      raw[62:52] = 11'($urandom_range(990, 1024));
    return make_sample(raw, kind, sig);
  endfunction

  task automatic run_directed();
    send_sample(make_sample(64'h7F, pcmsfc_pkg::KIND_I8, 6'd8));
    send_sample(make_sample(64'h80, pcmsfc_pkg::KIND_I8, 6'd0));
    send_sample(make_sample(64'h7FFF, pcmsfc_pkg::KIND_I16, 6'd16));
    send_sample(make_sample(64'hFFFF_FFFF_FFFF_8000, pcmsfc_pkg::KIND_I16, 6'd63));
    send_sample(make_sample(64'h7FFF_FFFF, pcmsfc_pkg::KIND_I32, 6'd32));
    send_sample(make_sample(64'h8000_0000, pcmsfc_pkg::KIND_I32, 6'd1));
    send_sample(make_sample(64'h3F80_0000, pcmsfc_pkg::KIND_F32, 6'd0));
    send_sample(make_sample(64'hBF80_0000, pcmsfc_pkg::KIND_F32, 6'd0));
    send_sample(make_sample(64'h7FC0_0001, pcmsfc_pkg::KIND_F32, 6'd0));
    send_sample(make_sample(64'hFF80_0000, pcmsfc_pkg::KIND_F32, 6'd0));
    send_sample(make_sample(64'h0000_0001, pcmsfc_pkg::KIND_F32, 6'd0));
    send_sample(make_sample(64'h3FE0_0000_0000_0000, pcmsfc_pkg::KIND_F64, 6'd0));
    send_sample(make_sample(64'hBFF0_0000_0000_0000, pcmsfc_pkg::KIND_F64, 6'd0));
    send_sample(make_sample(64'hFFF0_0000_2000_0001, pcmsfc_pkg::KIND_F64, 6'd0));
    send_sample(make_sample(64'h7FF0_0000_0000_0000, pcmsfc_pkg::KIND_F64, 6'd0));
    send_sample(make_sample(64'h8000_0000_0000_0001, pcmsfc_pkg::KIND_F64, 6'd0));
    send_sample(make_sample(64'h3810_0000_0000_0001, pcmsfc_pkg::KIND_F64, 6'd0));
    send_sample(make_sample('1, 3'd5, 6'd16));
    send_sample(make_sample('1, 3'd7, 6'd16));
  endtask

  // Output formats visited: valid integer, float widths and bad widths.
  logic [6:0] fmt_bits[10]  = '{7'd16, 7'd24, 7'd32, 7'd64, 7'd32, 7'd0, 7'd127,
                                 7'd127, 7'd16, 7'd24};
  logic       fmt_float[10] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                                 1'b1, 1'b1, 1'b0};

  initial begin
    int wait_cycles;
    sb.reset_format();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // Reset format first, then each configured format.
    run_directed();
    for (int i = 0; i < 200; i++) send_sample(random_sample());
    for (int f = 0; f < 10; f++) begin
      wait_drained();
      write_cfg(pcmsfc_pkg::REG_OUT_SAMPLE_BITS, {1'b0, fmt_bits[f]});
      write_cfg(pcmsfc_pkg::REG_OUT_IS_FLOAT, {7'd0, fmt_float[f]});
      run_directed();
      for (int i = 0; i < 160; i++) begin
        if (f == 2 && i == 80) wait_drained();
        send_sample(random_sample());
      end
    end
    // Drain the pipeline with a bounded wait.
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Converted %0d samples over 11 output formats, %0d results checked,",
             samples_sent, sb.checked);
    $display("including %0d error results from bad kinds or widths.", sb.errors_seen);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
